FILE: hdl/lrupr_pkg.sv
package lrupr_pkg;

	localparam int MAX_FRAMES = 8;
	localparam int PAGE_BITS  = 16;
	localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int RANK_W     = IDX_W;
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int CFG_W      = 4;
	localparam int FAULT_W    = 32;

	// Search state rippled from one cell to the next.
	typedef struct packed {
		logic                 found;
		logic [IDX_W-1:0]     hit_idx;
		logic [RANK_W-1:0]    hit_rank;
		logic                 empty;
		logic [IDX_W-1:0]     empty_idx;
		logic                 any;
		logic [RANK_W-1:0]    best_rank;
		logic [IDX_W-1:0]     best_idx;
		logic [PAGE_BITS-1:0] best_page;
	} chain_t;

	// Update command broadcast to every cell once the search is resolved.
	typedef struct packed {
		logic                 en;
		logic                 hit;
		logic [IDX_W-1:0]     slot;
		logic [RANK_W-1:0]    hit_rank;
		logic [PAGE_BITS-1:0] page;
	} upd_t;

endpackage

FILE: hdl/lrupr_cell.sv
module lrupr_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [lrupr_pkg::IDX_W-1:0]     idx,
	input  logic [lrupr_pkg::CNT_W-1:0]     n_active,
	input  logic [lrupr_pkg::PAGE_BITS-1:0] cur_page,
	input  lrupr_pkg::chain_t               chain_i,
	output lrupr_pkg::chain_t               chain_o,
	input  lrupr_pkg::upd_t                 upd
);

	logic [lrupr_pkg::PAGE_BITS-1:0] page_q;
	logic                            valid_q;
	logic [lrupr_pkg::RANK_W-1:0]    rank_q;

	logic active;
	logic match;
	logic take_empty;
	logic take_best;
	logic is_slot;
	logic age_ok;

	assign active     = lrupr_pkg::CNT_W'(idx) < n_active;
	assign match      = active && valid_q && (page_q == cur_page);
	assign take_empty = active && !valid_q && !chain_i.empty;
	assign take_best  = active && (!chain_i.any || (rank_q > chain_i.best_rank));

	always_comb begin
		chain_o = chain_i;
		if (match && !chain_i.found) begin
			chain_o.found    = 1'b1;
			chain_o.hit_idx  = idx;
			chain_o.hit_rank = rank_q;
		end
		if (take_empty) begin
			chain_o.empty     = 1'b1;
			chain_o.empty_idx = idx;
		end
		if (take_best) begin
			chain_o.best_rank = rank_q;
			chain_o.best_idx  = idx;
			chain_o.best_page = page_q;
		end
		chain_o.any = chain_i.any | active;
	end

	assign is_slot = (upd.slot == idx);
	assign age_ok  = rank_q < lrupr_pkg::RANK_W'(lrupr_pkg::MAX_FRAMES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.en) begin
			if (is_slot) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (active && valid_q && age_ok) begin
				// On a hit only frames younger than the hit frame grow older.
				if (!upd.hit || (rank_q < upd.hit_rank)) begin
					rank_q <= rank_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && !upd.hit && is_slot) begin
			page_q <= upd.page;
		end
	end

endmodule

FILE: hdl/lru_page_replacement_top.sv
// LRU page replacement over eight fully associative page frames. Each request on the
// s_ side carries one page number; each one yields exactly one result on the m_ side
// that reports hit or fault, the frame now holding the page, the evicted page if a
// resident one was replaced, and the saturating fault count. The frames sit in a row
// of identical cells, each holding one page, its valid bit and its recency rank (0 is
// most recent). For each request the page is first captured, then the lookup ripples
// through the cell row and the recency update is applied; no new request is taken
// while a lookup is pending. The lookup writes the single result register, so a
// result that is still waiting holds off the next request until it is taken. The
// frames_in_use register (reset value 8; 0 acts as 1, above 8 acts as 8) limits
// replacement to the lowest frames and must only be written while idle.
module lru_page_replacement_top (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: frames_in_use.
	input  logic        cfg_wen,
	input  logic [3:0]  cfg_wdata,
	// Request stream. s_tdata: page_number[15:0].
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,
	// Result stream. m_tdata: hit[0], frame_index[3:1], evicted_valid[4],
	// evicted_page[20:5], fault_count[52:21], zero padding[55:53].
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata
);

	localparam int NF = lrupr_pkg::MAX_FRAMES;

	logic [lrupr_pkg::CFG_W-1:0]     frames_in_use_q;
	logic [lrupr_pkg::CNT_W-1:0]     n_active;
	logic                            busy_q;
	logic [lrupr_pkg::PAGE_BITS-1:0] page_s1;
	logic [lrupr_pkg::FAULT_W-1:0]   fault_q;

	lrupr_pkg::chain_t chain [0:NF];
	lrupr_pkg::upd_t   upd;

	logic                            in_acc;
	logic                            ev_valid;
	logic [lrupr_pkg::IDX_W-1:0]     slot;
	logic [lrupr_pkg::FAULT_W-1:0]   fault_nxt;

	// Configuration register, taken at any write enable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= lrupr_pkg::CFG_W'(8);
		end else if (cfg_wen) begin
			frames_in_use_q <= cfg_wdata;
		end
	end

	// Clamp the register to the range 1 .. MAX_FRAMES.
	always_comb begin
		if (frames_in_use_q == '0) begin
			n_active = lrupr_pkg::CNT_W'(1);
		end else if (32'(frames_in_use_q) > NF) begin
			n_active = lrupr_pkg::CNT_W'(NF);
		end else begin
			n_active = lrupr_pkg::CNT_W'(frames_in_use_q);
		end
	end

	// A request is taken when no lookup is pending and the result register will be
	// free by the time the lookup finishes.
	assign s_tready = !busy_q && (!m_tvalid || m_tready);
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			page_s1 <= s_tdata;
		end
	end

	// The search enters the row at frame 0 with nothing found yet.
	assign chain[0] = '0;

	for (genvar g = 0; g < NF; g++) begin : g_cell
		lrupr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (lrupr_pkg::IDX_W'(g)),
			.n_active (n_active),
			.cur_page (page_s1),
			.chain_i  (chain[g]),
			.chain_o  (chain[g+1]),
			.upd      (upd)
		);
	end

	// Resolve the frame: the hit frame, else the first empty frame, else the oldest.
	always_comb begin
		if (chain[NF].found) begin
			slot = chain[NF].hit_idx;
		end else if (chain[NF].empty) begin
			slot = chain[NF].empty_idx;
		end else begin
			slot = chain[NF].best_idx;
		end
	end

	assign ev_valid = !chain[NF].found && !chain[NF].empty;

	always_comb begin
		upd.en       = busy_q;
		upd.hit      = chain[NF].found;
		upd.slot     = slot;
		upd.hit_rank = chain[NF].hit_rank;
		upd.page     = page_s1;
	end

	// The fault count saturates at its all-ones value.
	assign fault_nxt = (!chain[NF].found && (fault_q != '1)) ? fault_q + 1'b1 : fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= '0;
		end else if (busy_q) begin
			fault_q <= fault_nxt;
		end
	end

	// Result register. It is always free when the lookup finishes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (busy_q) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			m_tdata <= {3'b000, fault_nxt, (ev_valid ? chain[NF].best_page : 16'd0),
				ev_valid, slot, chain[NF].found};
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> busy_q && !s_tready)
		else $error("lookup not started after a request was taken");

	a_result_after_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> m_tvalid)
		else $error("no result after a lookup");

	a_fault_counts: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !chain[NF].found && (fault_q != '1) |=> fault_q == $past(fault_q) + 1'b1)
		else $error("fault not counted");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[4]))
		else $error("eviction reported on a hit");

endmodule
